>>> hw/rtl/dgps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgps_pkg
// shared types, event codes and register reset values for the display and
// radio power sequencer
// ----------------------------------------------------------------------------
package dgps_pkg;

  localparam int OP_W   = 4;
  localparam int TS_W   = 32;
  localparam int CFG_IDX_W = 2;

  // event codes
  localparam logic [OP_W-1:0] OP_TICK      = 4'd0;
  localparam logic [OP_W-1:0] OP_BUTTON    = 4'd1;
  localparam logic [OP_W-1:0] OP_DISPLAY   = 4'd2;
  localparam logic [OP_W-1:0] OP_ALERT     = 4'd3;
  localparam logic [OP_W-1:0] OP_SAFE      = 4'd4;
  localparam logic [OP_W-1:0] OP_RADIO_REQ = 4'd5;
  localparam logic [OP_W-1:0] OP_RADIO_REL = 4'd6;
  localparam logic [OP_W-1:0] OP_LOCK      = 4'd7;
  localparam logic [OP_W-1:0] OP_UNLOCK    = 4'd8;
  localparam logic [OP_W-1:0] OP_INIT      = 4'd9;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIO_WAKE_DLY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIO_IDLE_TMO  = 2'd2;

  // register reset values
  localparam logic [TS_W-1:0] DISPLAY_TIMEOUT_RST = 32'd30000;
  localparam logic [TS_W-1:0] RADIO_WAKE_DLY_RST  = 32'd15000;
  localparam logic [TS_W-1:0] RADIO_IDLE_TMO_RST  = 32'd5000;

  typedef struct packed {
    logic [TS_W-1:0] disp_tmo_ms;
    logic [TS_W-1:0] radio_wake_delay_ms;
    logic [TS_W-1:0] radio_idle_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic display_wake_cmd;
    logic display_sleep_cmd;
    logic radio_wake_cmd;
    logic radio_sleep_cmd;
    logic display_on;
    logic radio_on;
    logic radio_ready;
    logic sleep_locked;
  } result_t;

endpackage

>>> hw/rtl/dgps_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgps_cfg_regs
// timeout and delay registers behind the plain write port
// ----------------------------------------------------------------------------
module dgps_cfg_regs
  import dgps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TS_W-1:0]      cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DISPLAY_TIMEOUT: cfg_nxt.disp_tmo_ms           = cfg_wdata;
        REG_RADIO_WAKE_DLY:  cfg_nxt.radio_wake_delay_ms   = cfg_wdata;
        REG_RADIO_IDLE_TMO:  cfg_nxt.radio_idle_timeout_ms = cfg_wdata;
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.disp_tmo_ms           <= DISPLAY_TIMEOUT_RST;
      cfg_r.radio_wake_delay_ms   <= RADIO_WAKE_DLY_RST;
      cfg_r.radio_idle_timeout_ms <= RADIO_IDLE_TMO_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/dgps_event_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgps_event_core
// sequencer flags and timestamp marks, updated once per item
// ----------------------------------------------------------------------------
module dgps_event_core
  import dgps_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic [OP_W-1:0] op,
  input  logic [TS_W-1:0] now_ms,
  input  cfg_t            cfg,
  output result_t         res
);

  logic            lock_r, lock_nxt;
  logic            disp_r, disp_nxt;
  logic            force_r, force_nxt;
  logic            req_r, req_nxt;
  logic            ready_r, ready_nxt;
  logic [TS_W-1:0] disp_mark_r, disp_mark_nxt;
  logic [TS_W-1:0] wake_mark_r, wake_mark_nxt;
  logic [TS_W-1:0] idle_mark_r, idle_mark_nxt;

  logic disp_expired;
  logic wake_elapsed;
  logic idle_expired;
  logic p_dwake, p_dsleep, p_rwake, p_rsleep;

  // wrap-around elapsed time compares
  assign disp_expired = (now_ms - disp_mark_r) >= cfg.disp_tmo_ms;
  assign wake_elapsed = (now_ms - wake_mark_r) >= cfg.radio_wake_delay_ms;
  assign idle_expired = (now_ms - idle_mark_r) >= cfg.radio_idle_timeout_ms;

  always_comb begin
    lock_nxt      = lock_r;
    disp_nxt      = disp_r;
    force_nxt     = force_r;
    req_nxt       = req_r;
    ready_nxt     = ready_r;
    disp_mark_nxt = disp_mark_r;
    wake_mark_nxt = wake_mark_r;
    idle_mark_nxt = idle_mark_r;
    p_dwake       = 1'b0;
    p_dsleep      = 1'b0;
    p_rwake       = 1'b0;
    p_rsleep      = 1'b0;

    unique case (op) inside
      OP_TICK: begin
        if (disp_r && !force_r && disp_expired) begin
          p_dsleep = 1'b1;
          disp_nxt = 1'b0;
        end
        if (req_r && !ready_r && wake_elapsed) begin
          ready_nxt = 1'b1;
        end
        // auto sleep wins over the ready mark of the same tick
        if (req_r && !lock_r && idle_expired) begin
          p_rsleep  = 1'b1;
          req_nxt   = 1'b0;
          ready_nxt = 1'b0;
        end
      end
      OP_BUTTON, OP_DISPLAY: begin
        p_dwake       = 1'b1;
        disp_nxt      = 1'b1;
        disp_mark_nxt = now_ms;
      end
      OP_ALERT, OP_RADIO_REQ: begin
        if (op == OP_ALERT) begin
          lock_nxt      = 1'b1;
          force_nxt     = 1'b1;
          p_dwake       = 1'b1;
          disp_nxt      = 1'b1;
          disp_mark_nxt = now_ms;
        end
        idle_mark_nxt = now_ms;
        if (!req_r) begin
          p_rwake       = 1'b1;
          req_nxt       = 1'b1;
          ready_nxt     = 1'b0;
          wake_mark_nxt = now_ms;
        end
      end
      OP_SAFE: begin
        force_nxt     = 1'b0;
        p_dsleep      = 1'b1;
        disp_nxt      = 1'b0;
        idle_mark_nxt = now_ms - cfg.radio_idle_timeout_ms;
      end
      OP_RADIO_REL: idle_mark_nxt = now_ms;
      OP_LOCK:      lock_nxt = 1'b1;
      OP_UNLOCK:    lock_nxt = 1'b0;
      OP_INIT: begin
        lock_nxt      = 1'b0;
        disp_nxt      = 1'b0;
        force_nxt     = 1'b0;
        req_nxt       = 1'b0;
        ready_nxt     = 1'b0;
        p_dsleep      = 1'b1;
        p_rsleep      = 1'b1;
        disp_mark_nxt = now_ms;
        idle_mark_nxt = now_ms;
      end
      default: ; // unused codes only report status
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_r      <= 1'b0;
      disp_r      <= 1'b0;
      force_r     <= 1'b0;
      req_r       <= 1'b0;
      ready_r     <= 1'b0;
      disp_mark_r <= '0;
      wake_mark_r <= '0;
      idle_mark_r <= '0;
    end else if (fire) begin
      lock_r      <= lock_nxt;
      disp_r      <= disp_nxt;
      force_r     <= force_nxt;
      req_r       <= req_nxt;
      ready_r     <= ready_nxt;
      disp_mark_r <= disp_mark_nxt;
      wake_mark_r <= wake_mark_nxt;
      idle_mark_r <= idle_mark_nxt;
    end
  end

  always_comb begin
    res.display_wake_cmd  = p_dwake;
    res.display_sleep_cmd = p_dsleep;
    res.radio_wake_cmd    = p_rwake;
    res.radio_sleep_cmd   = p_rsleep;
    res.display_on        = disp_nxt;
    res.radio_on          = req_nxt;
    res.radio_ready       = ready_nxt;
    res.sleep_locked      = lock_nxt;
  end

endmodule

>>> hw/rtl/display_gsm_power_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_gsm_power_sequencer_core
// power sequencer for a display and a radio modem, one event item in and
// one status item out
// ----------------------------------------------------------------------------
// The block takes one event item per clock cycle while in_stall is low and
// returns exactly one result item for each, in order. An item waits in the
// input register and is then evaluated in a single pass against the flags,
// the timestamp marks and the timeout registers; the command pulses and the
// new status land in the result register, so the sustained rate is one item
// per cycle while out_stall is low, set by the single registered update of
// the sequencer state. While the result register is held by out_stall the
// input register can still take one more item, after which in_stall rises.
// Elapsed times are taken modulo 2^32, so the millisecond counter may wrap
// freely. Timeout registers are written through the cfg port; the user must
// do so while no item is in flight (not enforced); unmapped indexes are ignored.
// ----------------------------------------------------------------------------
module display_gsm_power_sequencer_core
  import dgps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TS_W-1:0]      cfg_wdata,
  // event items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_op,
  input  logic [TS_W-1:0]      in_now_ms,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_display_wake_cmd,
  output logic                 out_display_sleep_cmd,
  output logic                 out_radio_wake_cmd,
  output logic                 out_radio_sleep_cmd,
  output logic                 out_display_on,
  output logic                 out_radio_on,
  output logic                 out_radio_ready,
  output logic                 out_sleep_locked
);

  cfg_t    cfg;
  result_t res;

  // input register
  logic            s1_valid_r, s1_valid_nxt;
  logic [OP_W-1:0] s1_op_r;
  logic [TS_W-1:0] s1_now_r;

  // result register
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  logic in_take;
  logic advance;
  logic fire;

  // result register free, or being emptied this cycle
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  // input register blocked only when full and unable to move on
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = advance ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r  <= in_op;
      s1_now_r <= in_now_ms;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  dgps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // state is committed only as the item moves into the result register
  dgps_event_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .op     (s1_op_r),
    .now_ms (s1_now_r),
    .cfg    (cfg),
    .res    (res)
  );

  assign out_valid             = out_valid_r;
  assign out_display_wake_cmd  = out_res_r.display_wake_cmd;
  assign out_display_sleep_cmd = out_res_r.display_sleep_cmd;
  assign out_radio_wake_cmd    = out_res_r.radio_wake_cmd;
  assign out_radio_sleep_cmd   = out_res_r.radio_sleep_cmd;
  assign out_display_on        = out_res_r.display_on;
  assign out_radio_on          = out_res_r.radio_on;
  assign out_radio_ready       = out_res_r.radio_ready;
  assign out_sleep_locked      = out_res_r.sleep_locked;

`ifndef ASSERT_OFF
  // input side only backs up when both registers are occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("in_stall raised with a free register");

  // an item held in the input register reaches the output once it frees up
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance) |=> out_valid_r)
    else $error("item dropped between input and result register");

  // ready is only ever reported for a requested radio
  a_ready_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_res_r.radio_ready || out_res_r.radio_on))
    else $error("radio ready without radio on");

  // a display wake pulse always leaves the display on and never pairs with sleep
  a_dwake: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.display_wake_cmd) |->
      (out_res_r.display_on && !out_res_r.display_sleep_cmd))
    else $error("display wake pulse inconsistent with status");
`endif

endmodule
